### hw/rtl/mccp_pkg.sv
// Shared definitions for the motor command frame packer: code widths,
// operation codes, register indexes and fixed mode frames. No dependencies.
package mccp_pkg;

	// Code widths of the quantized fields.
	localparam int POSITION_CODE_BITS = 16;
	localparam int GAIN_CODE_BITS     = 12;
	localparam int CODE_BITS_MAX      = (POSITION_CODE_BITS > GAIN_CODE_BITS) ?
		POSITION_CODE_BITS : GAIN_CODE_BITS;

	// Pipeline depth of one quantizer lane: clamp, offset, scale, then one
	// quotient bit per stage.
	localparam int LANE_STAGES = 3 + CODE_BITS_MAX;

	// Total width of the packed codes before truncation to the frame.
	localparam int PACK_W = POSITION_CODE_BITS + 4 * GAIN_CODE_BITS;

	localparam int VALUE_W = 32;
	localparam int LIMIT_W = 64;
	localparam int FRAME_W = 64;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [1:0] {
		OP_CONTROL = 2'd0,
		OP_ENTER   = 2'd1,
		OP_EXIT    = 2'd2,
		OP_ZERO    = 2'd3
	} op_t;

	localparam logic [CFG_INDEX_W-1:0] REG_POSITION  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TORQUE    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DAMPING   = 3'd4;

	localparam logic [FRAME_W-1:0] FRAME_ENTER = 64'hFFFF_FFFF_FFFF_FFFC;
	localparam logic [FRAME_W-1:0] FRAME_EXIT  = 64'hFFFF_FFFF_FFFF_FFFD;
	localparam logic [FRAME_W-1:0] FRAME_ZERO  = 64'hFFFF_FFFF_FFFF_FFFE;

endpackage

### hw/rtl/mccp_lane.sv
// One quantizer lane: clamp, offset, scale and a restoring divider with one
// quotient bit per pipeline stage. Depends on mccp_pkg.
module mccp_lane (
	input  logic                                 clk,
	input  logic [mccp_pkg::LANE_STAGES:1]       en,
	input  logic                                 wide_code,
	input  logic [mccp_pkg::VALUE_W-1:0]         value,
	input  logic [mccp_pkg::LIMIT_W-1:0]         limits,
	output logic [mccp_pkg::CODE_BITS_MAX-1:0]   code
);

	localparam int MB   = mccp_pkg::CODE_BITS_MAX;
	localparam int VW   = mccp_pkg::VALUE_W;
	localparam int NUMW = VW + MB;

	logic signed [VW-1:0] lo;
	logic signed [VW-1:0] hi;
	logic signed [VW-1:0] x;
	logic                 empty;

	assign lo    = limits[VW-1:0];
	assign hi    = limits[2*VW-1:VW];
	assign x     = value;
	assign empty = (hi <= lo);

	// Stage 1: clamp into the configured range.
	logic signed [VW-1:0] xc_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			if (x < lo) begin
				xc_s1 <= lo;
			end else if (x > hi) begin
				xc_s1 <= hi;
			end else begin
				xc_s1 <= x;
			end
		end
	end

	// Stage 2: offset from the minimum and the span. An empty range divides
	// zero by one so the code comes out as zero.
	logic [VW:0]   off_w;
	logic [VW:0]   span_w;
	logic [VW-1:0] off_s2;
	logic [VW-1:0] span_s2;

	assign off_w  = {xc_s1[VW-1], xc_s1} - {lo[VW-1], lo};
	assign span_w = {hi[VW-1], hi} - {lo[VW-1], lo};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			off_s2  <= empty ? '0 : off_w[VW-1:0];
			span_s2 <= empty ? VW'(1) : span_w[VW-1:0];
		end
	end

	// Stage 3: numerator = offset * (2^bits - 1), done as a shift and subtract.
	logic [NUMW-1:0] off_ext;
	logic [NUMW-1:0] num_w;
	logic [NUMW-1:0] num_s3;
	logic [VW-1:0]   span_s3;

	assign off_ext = NUMW'(off_s2);
	assign num_w   = (wide_code ? (off_ext << mccp_pkg::POSITION_CODE_BITS) :
		(off_ext << mccp_pkg::GAIN_CODE_BITS)) - off_ext;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			num_s3  <= num_w;
			span_s3 <= span_s2;
		end
	end

	// Divider stages. The quotient never exceeds 2^bits - 1, so the upper part
	// of the numerator is already below the divisor and MB steps suffice.
	logic [VW-1:0] rem_sn [1:MB];
	logic [MB-1:0] low_sn [1:MB];
	logic [MB-1:0] quo_sn [1:MB];
	logic [VW-1:0] dvs_sn [1:MB];

	for (genvar j = 1; j <= MB; j++) begin : g_div
		logic [VW-1:0] rem_in;
		logic [MB-1:0] low_in;
		logic [MB-1:0] quo_in;
		logic [VW-1:0] dvs_in;
		logic [VW:0]   trial;
		logic [VW:0]   diff;
		logic          take;

		if (j == 1) begin : g_first
			assign rem_in = num_s3[NUMW-1:MB];
			assign low_in = num_s3[MB-1:0];
			assign quo_in = '0;
			assign dvs_in = span_s3;
		end else begin : g_next
			assign rem_in = rem_sn[j-1];
			assign low_in = low_sn[j-1];
			assign quo_in = quo_sn[j-1];
			assign dvs_in = dvs_sn[j-1];
		end

		assign trial = {rem_in, low_in[MB-1]};
		assign diff  = trial - {1'b0, dvs_in};
		assign take  = (trial >= {1'b0, dvs_in});

		always_ff @(posedge clk) begin
			if (en[3+j]) begin
				rem_sn[j] <= take ? diff[VW-1:0] : trial[VW-1:0];
				low_sn[j] <= {low_in[MB-2:0], 1'b0};
				quo_sn[j] <= {quo_in[MB-2:0], take};
				dvs_sn[j] <= dvs_in;
			end
		end
	end

	assign code = quo_sn[MB];

endmodule

### hw/rtl/motor_can_command_packer_core.sv
// Top level of the motor command frame packer: configuration registers,
// pipeline control, five quantizer lanes and the frame output register.
// Depends on mccp_pkg and mccp_lane.

// The block turns one command into one eight-byte motor command payload.
// It accepts one command transfer per clock cycle when the output side does
// not stall and returns its frame through the lane stages and the frame
// output register; the depth is set by the divider in each lane, which
// resolves one quotient bit per stage after the clamp, offset and scale
// stages. Every stage holds its own valid bit and moves whenever the stage
// after it is empty or moving, so a stalled output keeps its frame while
// earlier empty stages still fill. Limit registers are written through the
// cfg channel, which is always ready; write them only while no command is
// in flight.
module motor_can_command_packer_core (
	input  logic         clk,
	input  logic         arst_n,
	// Command stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, lowest bit up: position_cmd[31:0], velocity_cmd[63:32],
	// torque_cmd[95:64], stiffness_cmd[127:96], damping_cmd[159:128].
	input  logic [159:0] s_tdata,
	// s_tuser: operation[1:0].
	input  logic [1:0]   s_tuser,
	// Frame stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata: frame_data[63:0], payload byte 0 in bits 63:56.
	output logic [63:0]  m_tdata,
	// Configuration write channel.
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam int LS  = mccp_pkg::LANE_STAGES;
	localparam int OS  = LS + 1;
	localparam int MB  = mccp_pkg::CODE_BITS_MAX;
	localparam int PB  = mccp_pkg::POSITION_CODE_BITS;
	localparam int GB  = mccp_pkg::GAIN_CODE_BITS;
	localparam int PW  = mccp_pkg::PACK_W;
	localparam int FW  = mccp_pkg::FRAME_W;
	localparam int VW  = mccp_pkg::VALUE_W;

	// Limit registers. A write to an index past the list is dropped.
	logic [mccp_pkg::LIMIT_W-1:0] lim_pos_q;
	logic [mccp_pkg::LIMIT_W-1:0] lim_vel_q;
	logic [mccp_pkg::LIMIT_W-1:0] lim_trq_q;
	logic [mccp_pkg::LIMIT_W-1:0] lim_kp_q;
	logic [mccp_pkg::LIMIT_W-1:0] lim_kd_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_pos_q <= '0;
			lim_vel_q <= '0;
			lim_trq_q <= '0;
			lim_kp_q  <= '0;
			lim_kd_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mccp_pkg::REG_POSITION:  lim_pos_q <= cfg_data;
				mccp_pkg::REG_VELOCITY:  lim_vel_q <= cfg_data;
				mccp_pkg::REG_TORQUE:    lim_trq_q <= cfg_data;
				mccp_pkg::REG_STIFFNESS: lim_kp_q  <= cfg_data;
				mccp_pkg::REG_DAMPING:   lim_kd_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Pipeline control. A stage may load when any stage from it to the
	// output is empty, or when the output transfer completes.
	logic [OS:1] vld_sn;
	logic [OS:1] en;

	for (genvar k = 1; k <= OS; k++) begin : g_en
		assign en[k] = m_tready | ~(&vld_sn[OS:k]);
	end

	assign s_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else begin
			if (en[1]) begin
				vld_sn[1] <= s_tvalid;
			end
			for (int k = 2; k <= OS; k++) begin
				if (en[k]) begin
					vld_sn[k] <= vld_sn[k-1];
				end
			end
		end
	end

	// The operation travels alongside the lanes.
	mccp_pkg::op_t op_sn [1:LS];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_sn[1] <= mccp_pkg::op_t'(s_tuser);
		end
		for (int k = 2; k <= LS; k++) begin
			if (en[k]) begin
				op_sn[k] <= op_sn[k-1];
			end
		end
	end

	// Quantizer lanes.
	logic [MB-1:0] code_pos;
	logic [MB-1:0] code_vel;
	logic [MB-1:0] code_trq;
	logic [MB-1:0] code_kp;
	logic [MB-1:0] code_kd;

	mccp_lane u_lane_pos (
		.clk       (clk),
		.en        (en[LS:1]),
		.wide_code (1'b1),
		.value     (s_tdata[VW-1:0]),
		.limits    (lim_pos_q),
		.code      (code_pos)
	);

	mccp_lane u_lane_vel (
		.clk       (clk),
		.en        (en[LS:1]),
		.wide_code (1'b0),
		.value     (s_tdata[2*VW-1:VW]),
		.limits    (lim_vel_q),
		.code      (code_vel)
	);

	mccp_lane u_lane_trq (
		.clk       (clk),
		.en        (en[LS:1]),
		.wide_code (1'b0),
		.value     (s_tdata[3*VW-1:2*VW]),
		.limits    (lim_trq_q),
		.code      (code_trq)
	);

	mccp_lane u_lane_kp (
		.clk       (clk),
		.en        (en[LS:1]),
		.wide_code (1'b0),
		.value     (s_tdata[4*VW-1:3*VW]),
		.limits    (lim_kp_q),
		.code      (code_kp)
	);

	mccp_lane u_lane_kd (
		.clk       (clk),
		.en        (en[LS:1]),
		.wide_code (1'b0),
		.value     (s_tdata[5*VW-1:4*VW]),
		.limits    (lim_kd_q),
		.code      (code_kd)
	);

	// Pack MSB-first: position, velocity, stiffness, damping, torque. Codes
	// that run past bit 0 are cut off and spare low bits stay zero.
	logic [PW+FW-1:0] packed_w;
	logic [FW-1:0]    frame_w;
	logic [FW-1:0]    frame_out_q;

	assign packed_w = {code_pos[PB-1:0], code_vel[GB-1:0], code_kp[GB-1:0],
		code_kd[GB-1:0], code_trq[GB-1:0], {FW{1'b0}}};

	always_comb begin
		case (op_sn[LS])
			mccp_pkg::OP_ENTER: frame_w = mccp_pkg::FRAME_ENTER;
			mccp_pkg::OP_EXIT:  frame_w = mccp_pkg::FRAME_EXIT;
			mccp_pkg::OP_ZERO:  frame_w = mccp_pkg::FRAME_ZERO;
			default:            frame_w = packed_w[PW+FW-1 -: FW];
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[OS]) begin
			frame_out_q <= frame_w;
		end
	end

	assign m_tvalid = vld_sn[OS];
	assign m_tdata  = frame_out_q;

endmodule

### hw/rtl/mccp_checker.sv
// Port-level checks for the motor command frame packer, bound to
// motor_can_command_packer_core. Depends only on the top-level ports.
module mccp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata
);

	// A frame that is offered stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("frame withdrawn before transfer");

	// A stalled frame keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("frame payload changed while stalled");

	// With the output moving, every stage moves, so commands are taken.
	a_ready_follow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("command stalled while output side is ready");

	// An empty output stage means the pipeline can always take a command.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("command stalled with output stage empty");

endmodule

bind motor_can_command_packer_core mccp_checker u_mccp_checker (.*);

### verif/tb_motor_can_command_packer_core.sv
// Self-checking testbench for motor_can_command_packer_core: directed and random
// commands, limit register writes and a bit-exact frame predictor.
// Depends on mccp_pkg and the packer RTL.

module tb_motor_can_command_packer_core;
	import mccp_pkg::*;

	// Watchdog limit in cycles without any transfer. The slowest correct stretch is
	// a long sender gap plus the pipeline depth plus a long output stall.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TARGET_COMMANDS = 450;
	localparam int REPORT_LIMIT = 10;
	// Indexes past the last limit register; writes there must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_DAMPING + 3'd1;

	// Limit settings used by the directed rows. KEEP leaves the registers alone.
	typedef enum logic [1:0] {
		PROFILE_KEEP,
		PROFILE_FULL,
		PROFILE_UNIT,
		PROFILE_EMPTY
	} limit_profile_t;

	// One directed command. The command word is packed as on s_tdata, position in
	// the lowest 32 bits. A pinned row carries its frame typed in by hand.
	typedef struct packed {
		limit_profile_t profile;
		op_t op;
		logic pinned;
		logic [FRAME_W-1:0] frame;
		logic [5*VALUE_W-1:0] cmd;
	} directed_row_t;

	localparam int NUM_DIRECTED = 23;
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;

	// Field order inside cmd, from the top: damping, stiffness, torque, velocity,
	// position. The frame holds position, velocity, stiffness, damping, torque
	// from bit 63 down, so a single full-scale field lands in a known bit range.
	directed_row_t directed_rows [NUM_DIRECTED] = '{
		// Reset limits are all zero, which is an empty range for every value.
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'h0, {5{Q_MAX}}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'h0, {5{Q_MIN}}},
		// Mode frames do not depend on the limits.
		'{PROFILE_KEEP, OP_ENTER, 1'b1, FRAME_ENTER, {5{32'h0}}},
		'{PROFILE_KEEP, OP_EXIT, 1'b1, FRAME_EXIT, {5{32'h0}}},
		'{PROFILE_KEEP, OP_ZERO, 1'b1, FRAME_ZERO, {5{32'h0}}},
		// Full signed range: the top of the range is full scale, the bottom is zero.
		'{PROFILE_FULL, OP_CONTROL, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, {5{Q_MAX}}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'h0, {5{Q_MIN}}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b0, 64'h0, {5{32'h0}}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b0, 64'h0, {5{32'hFFFF_FFFF}}},
		// One field at full scale at a time shows the packing order.
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'hFFFF_0000_0000_0000, {{4{Q_MIN}}, Q_MAX}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'h0000_0000_0000_0FFF,
			{Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'h0000_FFF0_0000_0000,
			{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'h0000_000F_FF00_0000,
			{Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'h0000_0000_00FF_F000,
			{Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN}},
		// A mode command ignores whatever values travel with it.
		'{PROFILE_KEEP, OP_ENTER, 1'b1, FRAME_ENTER, {5{Q_MAX}}},
		// Range of -1.0 to +1.0: values outside are clamped to the nearest end.
		'{PROFILE_UNIT, OP_CONTROL, 1'b1, 64'h0, {5{Q_MIN}}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, {5{Q_MAX}}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'h0, {5{Q_NEG_ONE}}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, {5{Q_ONE}}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b0, 64'h0,
			{32'h1234_5678, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_8000, 32'h0000_8000}},
		// Maximum equal to or below the minimum gives a zero code.
		'{PROFILE_EMPTY, OP_CONTROL, 1'b1, 64'h0, {5{Q_MAX}}},
		'{PROFILE_KEEP, OP_CONTROL, 1'b1, 64'h0, {5{32'h0005_0000}}},
		'{PROFILE_KEEP, OP_ZERO, 1'b1, FRAME_ZERO, {5{Q_MIN}}}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [159:0] s_tdata = '0;
	logic [1:0] s_tuser = OP_CONTROL;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = REG_POSITION;
	logic [63:0] cfg_data = '0;

	// Hand-typed expectation that travels alongside the command it belongs to.
	logic pinned_valid = 1'b0;
	logic [FRAME_W-1:0] pinned_frame = '0;

	// Copy of the limit registers as the block should hold them; reset is zero.
	logic [LIMIT_W-1:0] limit_model [0:REG_DAMPING] = '{default: '0};
	logic [FRAME_W-1:0] pending_frames [$];
	logic [FRAME_W-1:0] expected_frame;

	int mismatch_count = 0;
	int idle_cycles = 0;
	int frames_checked = 0;
	int limit_writes = 0;
	int commands_sent = 0;
	int settings_run = 0;
	int op_seen [4] = '{default: 0};

	motor_can_command_packer_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clamp a signed Q16.16 value into [min, max] and scale it onto 0 .. 2^bits-1,
	// rounding down. An empty range (max not above min) yields zero.
	function automatic logic [63:0] quantize_value(logic [31:0] raw, logic [63:0] limits,
			int bits);
		longint x;
		longint lo;
		longint hi;
		logic [63:0] scale;
		logic [63:0] span;
		logic [63:0] offs;
		x = $signed(raw);
		lo = $signed(limits[31:0]);
		hi = $signed(limits[63:32]);
		if (hi <= lo) begin
			return '0;
		end
		if (x < lo) x = lo;
		if (x > hi) x = hi;
		scale = (64'd1 << bits) - 64'd1;
		span = 64'(hi - lo);
		offs = 64'(x - lo);
		return (offs * scale) / span;
	endfunction

	// Expected payload for one command under the current limits. Codes are chained
	// MSB first into a wide word and then aligned to bit 63 of the frame, so code
	// widths whose sum differs from 64 drop or zero-fill the low end.
	function automatic logic [FRAME_W-1:0] pack_frame(op_t op, logic [159:0] cmd);
		logic [63:0] pos_code;
		logic [63:0] vel_code;
		logic [63:0] trq_code;
		logic [63:0] stf_code;
		logic [63:0] dmp_code;
		logic [127:0] wide;
		case (op)
			OP_ENTER: begin
				return FRAME_ENTER;
			end
			OP_EXIT: begin
				return FRAME_EXIT;
			end
			OP_ZERO: begin
				return FRAME_ZERO;
			end
			default: begin
			end
		endcase
		pos_code = quantize_value(cmd[31:0], limit_model[REG_POSITION], POSITION_CODE_BITS);
		vel_code = quantize_value(cmd[63:32], limit_model[REG_VELOCITY], GAIN_CODE_BITS);
		trq_code = quantize_value(cmd[95:64], limit_model[REG_TORQUE], GAIN_CODE_BITS);
		stf_code = quantize_value(cmd[127:96], limit_model[REG_STIFFNESS], GAIN_CODE_BITS);
		dmp_code = quantize_value(cmd[159:128], limit_model[REG_DAMPING], GAIN_CODE_BITS);
		wide = 128'(pos_code);
		wide = (wide << GAIN_CODE_BITS) | 128'(vel_code);
		wide = (wide << GAIN_CODE_BITS) | 128'(stf_code);
		wide = (wide << GAIN_CODE_BITS) | 128'(dmp_code);
		wide = (wide << GAIN_CODE_BITS) | 128'(trq_code);
		wide = wide << (128 - PACK_W);
		return wide[127:64];
	endfunction

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("mismatch at %0t: %s, expected %h, got %h", $time, what, want, got);
		end
	endtask

	// Monitor. All three channels are sampled at the rising edge. A limit write
	// updates the register copy, an accepted command queues its expected frame,
	// and an accepted frame is compared with the oldest expectation. Any transfer
	// clears the idle counter that the watchdog reads.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				limit_writes++;
				if (cfg_index <= REG_DAMPING) begin
					limit_model[cfg_index] = cfg_data;
				end
			end
			if (s_tvalid && s_tready) begin
				op_seen[s_tuser]++;
				pending_frames.push_back(pinned_valid ? pinned_frame :
					pack_frame(op_t'(s_tuser), s_tdata));
			end
			if (m_tvalid && m_tready) begin
				frames_checked++;
				if (pending_frames.size() == 0) begin
					note_mismatch("frame with nothing pending", '0, m_tdata);
				end else begin
					expected_frame = pending_frames.pop_front();
					if (m_tdata !== expected_frame) begin
						note_mismatch("frame_data", expected_frame, m_tdata);
					end
				end
			end
			if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
	end

	// Watchdog: the run ends as a failure once nothing has moved for too long.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
		$display("watchdog expired with %0d frames outstanding", pending_frames.size());
		$display("** motor_can_command_packer_core: FAILED **");
		$finish;
	end

	// Output side back-pressure. Mostly ready, with short stalls, the odd long
	// stall, and calm stretches in which ready never drops.
	initial begin
		int stall_left;
		int calm_left;
		int roll;
		stall_left = 0;
		calm_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 3) calm_left = $urandom_range(50, 200);
					else if (roll < 8) stall_left = $urandom_range(10, 40);
					else if (roll < 35) stall_left = $urandom_range(1, 3);
				end
			end
		end
	end

	// Sender gap before the next command: usually none or short, sometimes long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one command and hold it until the transfer completes. Valid stays
	// high across back-to-back commands, so it is never lowered and raised at once.
	task automatic send_command(op_t op, logic [159:0] cmd, logic pinned,
			logic [FRAME_W-1:0] frame, int gap);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= cmd;
		pinned_valid <= pinned;
		pinned_frame <= frame;
		do @(posedge clk); while (!s_tready);
		commands_sent++;
	endtask

	// Stop sending and wait until every expected frame has come back. The block
	// answers every command, so an empty queue means the pipeline is idle.
	task automatic wait_for_frames();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_frames.size() != 0) @(negedge clk);
	endtask

	task automatic write_limit_reg(logic [CFG_INDEX_W-1:0] index, logic [LIMIT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Every batch of limit writes ends with a write to an unused index, which the
	// block must ignore, and then releases the channel.
	task automatic finish_limit_writes();
		write_limit_reg(REG_UNUSED_FIRST + 3'($urandom_range(0, 2)), {$urandom, $urandom});
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	function automatic logic [LIMIT_W-1:0] profile_limits(limit_profile_t profile, int reg_idx);
		case (profile)
			PROFILE_FULL: begin
				return {Q_MAX, Q_MIN};
			end
			PROFILE_UNIT: begin
				return {Q_ONE, Q_NEG_ONE};
			end
			default: begin
				// Alternate between max equal to min and max below min.
				return (reg_idx % 2 == 0) ? {32'h0005_0000, 32'h0005_0000} : {Q_MIN, Q_MAX};
			end
		endcase
	endfunction

	// Random limits for one register: {max, min}. Covers the full range, wide and
	// narrow spans, realistic Q16.16 ranges, empty ranges and raw noise.
	function automatic logic [LIMIT_W-1:0] random_limits();
		logic [31:0] lo;
		logic [31:0] hi;
		int kind;
		kind = $urandom_range(0, 99);
		lo = $urandom;
		hi = $urandom;
		if (kind < 10) begin
			return {Q_MAX, Q_MIN};
		end else if (kind < 40) begin
			if ($signed(lo) > $signed(hi)) return {lo, hi};
			return {hi, lo};
		end else if (kind < 60) begin
			if ($signed(lo) > $signed(32'h7FFF_0000)) lo = 32'h7FFF_0000;
			return {lo + 32'($urandom_range(1, 64)), lo};
		end else if (kind < 80) begin
			lo = -(32'($urandom_range(0, 200)) << 16) - 32'($urandom_range(0, 65535));
			hi = (32'($urandom_range(1, 200)) << 16) + 32'($urandom_range(0, 65535));
			return {hi, lo};
		end else if (kind < 90) begin
			if ($urandom_range(0, 1) == 0) return {lo, lo};
			if ($signed(lo) > $signed(hi)) return {hi, lo};
			return {lo, hi};
		end
		return {hi, lo};
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return 32'h0;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// One random command value, aimed mostly at the range and its edges.
	function automatic logic [31:0] pick_command_value(logic [LIMIT_W-1:0] limits);
		longint lo;
		longint hi;
		longint unsigned span;
		int roll;
		lo = $signed(limits[31:0]);
		hi = $signed(limits[63:32]);
		roll = $urandom_range(0, 99);
		if (roll < 35 || hi <= lo) begin
			return (roll % 4 == 0) ? pick_extreme() : $urandom;
		end else if (roll < 70) begin
			span = longint'(hi - lo) + 1;
			return 32'(lo + longint'({$urandom, $urandom} % span));
		end else if (roll < 80) begin
			return ($urandom_range(0, 1) == 0) ? 32'(lo) : 32'(hi);
		end else if (roll < 90) begin
			return ($urandom_range(0, 1) == 0) ? 32'(lo - 1) : 32'(hi + 1);
		end
		return pick_extreme();
	endfunction

	// Main sequence: reset, the directed rows, then random settings each followed
	// by a burst of commands, and finally drain and report.
	initial begin
		logic [159:0] cmd;
		op_t op;
		int phase_len;
		bit no_gaps;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (directed_rows[i].profile != PROFILE_KEEP) begin
				wait_for_frames();
				for (int r = REG_POSITION; r <= REG_DAMPING; r++) begin
					write_limit_reg(3'(r), profile_limits(directed_rows[i].profile, r));
				end
				finish_limit_writes();
			end
			send_command(directed_rows[i].op, directed_rows[i].cmd, directed_rows[i].pinned,
				directed_rows[i].frame, pick_gap());
		end

		while (commands_sent < TARGET_COMMANDS) begin
			// Limits may only change with the pipeline empty.
			wait_for_frames();
			for (int r = REG_POSITION; r <= REG_DAMPING; r++) begin
				write_limit_reg(3'(r), random_limits());
			end
			finish_limit_writes();
			no_gaps = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(20, 60);
			repeat (phase_len) begin
				op = ($urandom_range(0, 99) < 75) ? OP_CONTROL : op_t'($urandom_range(1, 3));
				cmd[31:0] = pick_command_value(limit_model[REG_POSITION]);
				cmd[63:32] = pick_command_value(limit_model[REG_VELOCITY]);
				cmd[95:64] = pick_command_value(limit_model[REG_TORQUE]);
				cmd[127:96] = pick_command_value(limit_model[REG_STIFFNESS]);
				cmd[159:128] = pick_command_value(limit_model[REG_DAMPING]);
				send_command(op, cmd, 1'b0, '0, no_gaps ? 0 : pick_gap());
				// Now and then the sender holds off until the block has drained.
				if ($urandom_range(0, 49) == 0) wait_for_frames();
			end
		end

		wait_for_frames();
		repeat (LANE_STAGES + 8) @(negedge clk);
		if (pending_frames.size() != 0) begin
			$display("%0d expected frames never arrived", pending_frames.size());
			mismatch_count += pending_frames.size();
		end
		$display("Sent %0d commands (%0d control, %0d enter, %0d exit, %0d set-zero), %0d frames checked.",
			commands_sent, op_seen[OP_CONTROL], op_seen[OP_ENTER], op_seen[OP_EXIT],
			op_seen[OP_ZERO], frames_checked);
		$display("Applied %0d limit settings through %0d register writes; %0d mismatches.",
			settings_run, limit_writes, mismatch_count);
		if (mismatch_count == 0) begin
			$display("** motor_can_command_packer_core: PASSED **");
		end else begin
			$display("** motor_can_command_packer_core: FAILED **");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/mccp_pkg.sv
hw/rtl/mccp_lane.sv
hw/rtl/motor_can_command_packer_core.sv
hw/rtl/mccp_checker.sv
verif/tb_motor_can_command_packer_core.sv
